// ===== src/sr_swm_pkg.sv =====
// ----------------------------------------------------------------------------
// sr_swm_pkg
// Shared types and constants of the selective-repeat send window manager.
// ----------------------------------------------------------------------------
package sr_swm_pkg;

    localparam int MAX_SEQ = 64;
    localparam int SEQ_W   = $clog2(MAX_SEQ);
    localparam int SCNT_W  = SEQ_W + 1;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 16;
    localparam int IDLE_W  = 8;
    localparam int ACKB_W  = 8;

    localparam logic [SCNT_W-1:0] SEQ_MIN = SCNT_W'(2);
    localparam logic [SCNT_W-1:0] SEQ_MAX = SCNT_W'(MAX_SEQ);

    localparam logic [6:0]  RST_SEQ_COUNT     = 7'd20;
    localparam logic [5:0]  RST_WINDOW_SIZE   = 6'd5;
    localparam logic [15:0] RST_TOTAL_PACKETS = 16'd32;
    localparam logic [7:0]  RST_TIMEOUT_LIMIT = 8'd20;

    typedef enum logic [1:0] {
        CFG_SEQ_COUNT     = 2'd0,
        CFG_WINDOW_SIZE   = 2'd1,
        CFG_TOTAL_PACKETS = 2'd2,
        CFG_TIMEOUT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_IDLE = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_EXEC,
        ST_SLIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic norm;
        logic exec;
        logic slide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_norm;
        logic is_ack;
        logic can_slide;
        logic out_free;
    } t_status;

endpackage

// ===== src/sr_swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sr_swm_ctrl
// Sequencer: accepts a request, normalizes the window pointers, executes the
// opcode, slides the base one slot per cycle and hands the result over.
// ----------------------------------------------------------------------------
module sr_swm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sr_swm_pkg::t_status i_status,
    output sr_swm_pkg::t_cmd    o_cmd
);
    import sr_swm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_NORM;
                end
            end
            ST_NORM: begin
                // Pointers left over from a larger sequence count are
                // reduced one subtraction per cycle.
                if (i_status.need_norm) begin
                    o_cmd.norm = 1'b1;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.is_ack ? ST_SLIDE : ST_DONE;
            end
            ST_SLIDE: begin
                if (i_status.can_slide) begin
                    o_cmd.slide = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sr_swm_dp.sv =====
// ----------------------------------------------------------------------------
// sr_swm_dp
// Datapath: configuration registers, window pointers, acknowledge marks,
// counters and the output register.
// ----------------------------------------------------------------------------
module sr_swm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sr_swm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [1:0]                   i_opcode,
    input  logic [7:0]                   i_ack_byte,
    input  sr_swm_pkg::t_cmd             i_cmd,
    output sr_swm_pkg::t_status          o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_send_ok,
    output logic [5:0]                   o_send_seq,
    output logic [15:0]                  o_send_index,
    output logic                         o_ack_taken,
    output logic [5:0]                   o_window_base,
    output logic [15:0]                  o_acked_total,
    output logic                         o_timeout_fired,
    output logic                         o_all_done
);
    import sr_swm_pkg::*;

    // Configuration.
    logic [6:0]  r_seq_count;
    logic [5:0]  r_window_size;
    logic [15:0] r_total_packets;
    logic [7:0]  r_timeout_limit;

    // Window state.
    logic [MAX_SEQ-1:0] r_marks;
    logic [SEQ_W-1:0]   r_base;
    logic [SEQ_W-1:0]   r_next;
    logic [IDX_W-1:0]   r_next_index;
    logic [IDX_W-1:0]   r_acked;
    logic [IDLE_W-1:0]  r_idle;

    // Current request and its per-item flags.
    t_opcode            r_op;
    logic [ACKB_W-1:0]  r_ack_byte;
    logic               r_send_ok;
    logic [SEQ_W-1:0]   r_send_seq;
    logic [IDX_W-1:0]   r_send_index;
    logic               r_ack_taken;
    logic               r_fired;

    // Output register.
    logic               r_out_valid;
    logic               r_o_send_ok;
    logic [SEQ_W-1:0]   r_o_send_seq;
    logic [IDX_W-1:0]   r_o_send_index;
    logic               r_o_ack_taken;
    logic [SEQ_W-1:0]   r_o_window_base;
    logic [IDX_W-1:0]   r_o_acked_total;
    logic               r_o_fired;
    logic               r_o_all_done;

    logic [SCNT_W-1:0]  s_eff;
    logic [SEQ_W-1:0]   half;
    logic [SEQ_W-1:0]   w_eff;
    logic               base_hi;
    logic               next_hi;
    logic [SCNT_W-1:0]  dist_nb;
    logic [SCNT_W-1:0]  dist_ib;
    logic [ACKB_W-1:0]  ack_idx;
    logic               idx_ok;
    logic               grant;
    logic               ack_hit;
    logic [SEQ_W-1:0]   next_inc;
    logic [SEQ_W-1:0]   base_inc;
    logic [IDLE_W:0]    idle_inc;

    always_comb begin
        if (r_seq_count < SEQ_MIN) begin
            s_eff = SEQ_MIN;
        end else if (r_seq_count > SEQ_MAX) begin
            s_eff = SEQ_MAX;
        end else begin
            s_eff = r_seq_count;
        end
        half  = s_eff[SCNT_W-1:1];
        w_eff = (r_window_size == '0) ? SEQ_W'(1) : r_window_size;
        if (w_eff > half) begin
            w_eff = half;
        end
    end

    assign base_hi = {1'b0, r_base} >= s_eff;
    assign next_hi = {1'b0, r_next} >= s_eff;

    // Modular distances; both operands are below s_eff once normalized.
    assign dist_nb = (r_next >= r_base) ? SCNT_W'(r_next - r_base)
                                        : {1'b0, r_next} + s_eff - {1'b0, r_base};
    assign ack_idx = r_ack_byte - 8'd1;
    assign idx_ok  = ack_idx < {1'b0, s_eff};
    assign dist_ib = (ack_idx[SEQ_W-1:0] >= r_base)
                   ? SCNT_W'(ack_idx[SEQ_W-1:0] - r_base)
                   : {1'b0, ack_idx[SEQ_W-1:0]} + s_eff - {1'b0, r_base};

    assign grant   = (dist_nb < {1'b0, w_eff}) && !r_marks[r_next]
                   && (r_next_index < r_total_packets);
    assign ack_hit = idx_ok && (dist_ib < dist_nb);

    assign next_inc = ({1'b0, r_next} + SCNT_W'(1) == s_eff) ? '0 : r_next + SEQ_W'(1);
    assign base_inc = ({1'b0, r_base} + SCNT_W'(1) == s_eff) ? '0 : r_base + SEQ_W'(1);
    assign idle_inc = {1'b0, r_idle} + (IDLE_W+1)'(1);

    always_comb begin
        o_status.need_norm = base_hi || next_hi;
        o_status.is_ack    = (r_op == OP_ACK);
        o_status.can_slide = (r_base != r_next) && r_marks[r_base];
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count     <= RST_SEQ_COUNT;
            r_window_size   <= RST_WINDOW_SIZE;
            r_total_packets <= RST_TOTAL_PACKETS;
            r_timeout_limit <= RST_TIMEOUT_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEQ_COUNT:     r_seq_count     <= i_cfg_data[6:0];
                CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[5:0];
                CFG_TOTAL_PACKETS: r_total_packets <= i_cfg_data[15:0];
                CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks      <= '0;
            r_base       <= '0;
            r_next       <= '0;
            r_next_index <= '0;
            r_acked      <= '0;
            r_idle       <= '0;
        end else if (i_cmd.norm) begin
            if (base_hi) begin
                r_base <= SEQ_W'({1'b0, r_base} - s_eff);
            end
            if (next_hi) begin
                r_next <= SEQ_W'({1'b0, r_next} - s_eff);
            end
        end else if (i_cmd.exec) begin
            case (r_op)
                OP_SEND: begin
                    if (grant) begin
                        r_next       <= next_inc;
                        r_next_index <= r_next_index + IDX_W'(1);
                    end
                end
                OP_ACK: begin
                    if (ack_hit) begin
                        r_marks[ack_idx[SEQ_W-1:0]] <= 1'b1;
                    end
                end
                OP_IDLE: begin
                    if (idle_inc > {1'b0, r_timeout_limit}) begin
                        r_next_index <= r_next_index - IDX_W'(dist_nb);
                        r_next       <= r_base;
                        r_idle       <= '0;
                    end else begin
                        r_idle <= idle_inc[IDLE_W-1:0];
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.slide) begin
            r_marks[r_base] <= 1'b0;
            r_base          <= base_inc;
            r_idle          <= '0;
            if (r_acked != '1) begin
                r_acked <= r_acked + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_opcode'(i_opcode);
            r_ack_byte <= i_ack_byte;
        end
        if (i_cmd.exec) begin
            r_send_ok    <= (r_op == OP_SEND) && grant;
            r_send_seq   <= ((r_op == OP_SEND) && grant) ? r_next : '0;
            r_send_index <= ((r_op == OP_SEND) && grant) ? r_next_index : '0;
            r_ack_taken  <= (r_op == OP_ACK) && ack_hit;
            r_fired      <= (r_op == OP_IDLE) && (idle_inc > {1'b0, r_timeout_limit});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_send_ok     <= r_send_ok;
            r_o_send_seq    <= r_send_seq;
            r_o_send_index  <= r_send_index;
            r_o_ack_taken   <= r_ack_taken;
            r_o_window_base <= r_base;
            r_o_acked_total <= r_acked;
            r_o_fired       <= r_fired;
            r_o_all_done    <= (r_acked == r_total_packets);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_ok       = r_o_send_ok;
    assign o_send_seq      = r_o_send_seq;
    assign o_send_index    = r_o_send_index;
    assign o_ack_taken     = r_o_ack_taken;
    assign o_window_base   = r_o_window_base;
    assign o_acked_total   = r_o_acked_total;
    assign o_timeout_fired = r_o_fired;
    assign o_all_done      = r_o_all_done;

endmodule

// ===== src/sr_send_window_manager.sv =====
// ----------------------------------------------------------------------------
// sr_send_window_manager
// Sender side of a selective-repeat sliding window.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (i_in_valid / o_in_ready) carries
// an opcode (send try, ack arrival, idle tick) and an ack byte. Exactly one
// result per request leaves on the output channel (o_out_valid / i_out_ready).
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data while no request is in flight.
// Sequence: a send try or idle tick passes through the normalize, execute and
// done states after it is accepted; an ack also passes through the slide
// state, where the base moves over each acknowledged slot in turn (up to the
// window size). After a sequence count change, both pointers are reduced
// together by one subtraction of the count per cycle until both lie below it.
// Throughput: one request at a time; the next request is accepted in the
// cycle after the result is loaded into the output register.
// A result waiting in the output register does not block acceptance; only
// when a finished result finds the output register still full does the
// block hold it until the receiver takes the pending one.
// Reset (synchronous, active low) clears all marks, pointers and counters and
// loads the default configuration.
// ----------------------------------------------------------------------------
module sr_send_window_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_ack_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_ok,
    output logic [5:0]  o_send_seq,
    output logic [15:0] o_send_index,
    output logic        o_ack_taken,
    output logic [5:0]  o_window_base,
    output logic [15:0] o_acked_total,
    output logic        o_timeout_fired,
    output logic        o_all_done
);
    import sr_swm_pkg::*;

    t_cmd    cmd;
    t_status status;

    sr_swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sr_swm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_ack_byte      (i_ack_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_send_ok       (o_send_ok),
        .o_send_seq      (o_send_seq),
        .o_send_index    (o_send_index),
        .o_ack_taken     (o_ack_taken),
        .o_window_base   (o_window_base),
        .o_acked_total   (o_acked_total),
        .o_timeout_fired (o_timeout_fired),
        .o_all_done      (o_all_done)
    );

endmodule

// ===== verif/sr_swm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_swm_checker
// Watches both channels and the register port of the send window manager,
// keeps its own copy of the window state, works out the response to every
// accepted request and compares each delivered response with it in order.
// ----------------------------------------------------------------------------
module sr_swm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_ack_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_send_ok,
    input  logic [5:0]  i_send_seq,
    input  logic [15:0] i_send_index,
    input  logic        i_ack_taken,
    input  logic [5:0]  i_window_base,
    input  logic [15:0] i_acked_total,
    input  logic        i_timeout_fired,
    input  logic        i_all_done,
    output int          o_mismatches,
    output int          o_results_due
);
    import sr_swm_pkg::*;

    typedef struct packed {
        logic        send_ok;
        logic [5:0]  send_seq;
        logic [15:0] send_index;
        logic        ack_taken;
        logic [5:0]  window_base;
        logic [15:0] acked_total;
        logic        timeout_fired;
        logic        all_done;
    } t_window_result;

    logic [6:0]  cfg_seq_count;
    logic [5:0]  cfg_window;
    logic [15:0] cfg_total;
    logic [7:0]  cfg_timeout;

    bit slot_acked [MAX_SEQ];
    int win_base;
    int win_next;
    int next_pkt;
    int acked_cnt;
    int idle_ticks;

    t_window_result window_results_due [$];

    function automatic int ring_gap(input int a, input int b, input int span);
        return (a + span - b) % span;
    endfunction

    // Applies one request to the window state and returns the response it gives.
    function automatic t_window_result predict_window_step(input t_opcode op,
                                                           input logic [7:0] ab);
        t_window_result r;
        int span;
        int win;
        int slot;
        int ticks;
        r    = '0;
        span = int'(cfg_seq_count);
        if (span < 2) span = 2;
        if (span > MAX_SEQ) span = MAX_SEQ;
        win = int'(cfg_window);
        if (win < 1) win = 1;
        if (win > span / 2) win = span / 2;

        // Pointers left over from a larger sequence count are folded back.
        win_base = win_base % span;
        win_next = win_next % span;

        case (op)
            OP_SEND: begin
                if (ring_gap(win_next, win_base, span) < win && !slot_acked[win_next]
                        && next_pkt < int'(cfg_total)) begin
                    r.send_ok    = 1'b1;
                    r.send_seq   = 6'(win_next);
                    r.send_index = 16'(next_pkt);
                    win_next     = (win_next + 1) % span;
                    next_pkt     = (next_pkt + 1) & 16'hFFFF;
                end
            end
            OP_ACK: begin
                // The ack byte carries the sequence plus one, so zero wraps to 255.
                slot = (int'(ab) + 255) % 256;
                if (slot < span
                        && ring_gap(slot, win_base, span) < ring_gap(win_next, win_base, span))
                begin
                    slot_acked[slot] = 1'b1;
                    r.ack_taken      = 1'b1;
                end
                while (win_base != win_next && slot_acked[win_base]) begin
                    slot_acked[win_base] = 1'b0;
                    win_base = (win_base + 1) % span;
                    if (acked_cnt < 16'hFFFF) acked_cnt++;
                    idle_ticks = 0;
                end
            end
            OP_IDLE: begin
                ticks = idle_ticks + 1;
                if (ticks > int'(cfg_timeout)) begin
                    next_pkt        = (next_pkt - ring_gap(win_next, win_base, span)) & 16'hFFFF;
                    win_next        = win_base;
                    idle_ticks      = 0;
                    r.timeout_fired = 1'b1;
                end else begin
                    idle_ticks = ticks;
                end
            end
            default: begin
            end
        endcase

        r.window_base = 6'(win_base);
        r.acked_total = 16'(acked_cnt);
        r.all_done    = (acked_cnt == int'(cfg_total));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            cfg_seq_count = RST_SEQ_COUNT;
            cfg_window    = RST_WINDOW_SIZE;
            cfg_total     = RST_TOTAL_PACKETS;
            cfg_timeout   = RST_TIMEOUT_LIMIT;
            foreach (slot_acked[k]) slot_acked[k] = 1'b0;
            win_base   = 0;
            win_next   = 0;
            next_pkt   = 0;
            acked_cnt  = 0;
            idle_ticks = 0;
            window_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEQ_COUNT:     cfg_seq_count = i_cfg_data[6:0];
                    CFG_WINDOW_SIZE:   cfg_window    = i_cfg_data[5:0];
                    CFG_TOTAL_PACKETS: cfg_total     = i_cfg_data[15:0];
                    CFG_TIMEOUT_LIMIT: cfg_timeout   = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                got = {i_send_ok, i_send_seq, i_send_index, i_ack_taken, i_window_base,
                       i_acked_total, i_timeout_fired, i_all_done};
                if (window_results_due.size() == 0) begin
                    report_mismatch("response with no request waiting", longint'(got), 0);
                end else begin
                    want = window_results_due.pop_front();
                    if (got.send_ok !== want.send_ok)
                        report_mismatch("send_ok", longint'(got.send_ok),
                                        longint'(want.send_ok));
                    if (got.send_seq !== want.send_seq)
                        report_mismatch("send_seq", longint'(got.send_seq),
                                        longint'(want.send_seq));
                    if (got.send_index !== want.send_index)
                        report_mismatch("send_index", longint'(got.send_index),
                                        longint'(want.send_index));
                    if (got.ack_taken !== want.ack_taken)
                        report_mismatch("ack_taken", longint'(got.ack_taken),
                                        longint'(want.ack_taken));
                    if (got.window_base !== want.window_base)
                        report_mismatch("window_base", longint'(got.window_base),
                                        longint'(want.window_base));
                    if (got.acked_total !== want.acked_total)
                        report_mismatch("acked_total", longint'(got.acked_total),
                                        longint'(want.acked_total));
                    if (got.timeout_fired !== want.timeout_fired)
                        report_mismatch("timeout_fired", longint'(got.timeout_fired),
                                        longint'(want.timeout_fired));
                    if (got.all_done !== want.all_done)
                        report_mismatch("all_done", longint'(got.all_done),
                                        longint'(want.all_done));
                end
            end

            if (i_in_valid && i_in_ready) begin
                window_results_due.push_back(
                    predict_window_step(t_opcode'(i_opcode), i_ack_byte));
            end
        end
        o_results_due = window_results_due.size();
    end

endmodule

// ===== verif/tb_sr_send_window_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sr_send_window_manager
// Drives send tries, acks and idle ticks into the send window manager under
// a series of window settings, with random gaps on both channels and one long
// receiver hold-off, while the checker compares every response.
// ----------------------------------------------------------------------------
module tb_sr_send_window_manager;

    import sr_swm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  ack_byte;
    logic        out_valid;
    logic        out_ready;
    logic        send_ok;
    logic [5:0]  send_seq;
    logic [15:0] send_index;
    logic        ack_taken;
    logic [5:0]  window_base;
    logic [15:0] acked_total;
    logic        timeout_fired;
    logic        all_done;

    int mismatches;
    int results_due;
    int cycle_count = 0;
    bit gaps_on = 1'b1;
    bit hold_off_due = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sr_send_window_manager dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_ack_byte      (ack_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_send_ok       (send_ok),
        .o_send_seq      (send_seq),
        .o_send_index    (send_index),
        .o_ack_taken     (ack_taken),
        .o_window_base   (window_base),
        .o_acked_total   (acked_total),
        .o_timeout_fired (timeout_fired),
        .o_all_done      (all_done)
    );

    sr_swm_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_ack_byte      (ack_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_send_ok       (send_ok),
        .i_send_seq      (send_seq),
        .i_send_index    (send_index),
        .i_ack_taken     (ack_taken),
        .i_window_base   (window_base),
        .i_acked_total   (acked_total),
        .i_timeout_fired (timeout_fired),
        .i_all_done      (all_done),
        .o_mismatches    (mismatches),
        .o_results_due   (results_due)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_ready <= 1'b0;
            end else if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if (hold_off_due) begin
                hold_off_due = 1'b0;
                hold = 150;
                out_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Valid stays high between back-to-back requests; it drops only for a gap or a drain.
    task automatic offer(input t_opcode op, input logic [7:0] ab);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        ack_byte <= ab;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    // Leaves the write enable high so back-to-back writes need no gap.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] seq_v, input logic [15:0] win_v,
                             input logic [15:0] total_v, input logic [15:0] tmo_v,
                             input int n_items);
        int pick;
        int seq_span;
        drain_results();
        write_reg(CFG_SEQ_COUNT, seq_v);
        write_reg(CFG_WINDOW_SIZE, win_v);
        write_reg(CFG_TOTAL_PACKETS, total_v);
        write_reg(CFG_TIMEOUT_LIMIT, tmo_v);
        cfg_we <= 1'b0;
        seq_span = int'(seq_v[6:0]);
        if (seq_span < 2) seq_span = 2;
        if (seq_span > MAX_SEQ) seq_span = MAX_SEQ;
        // Most acks name a sequence number in use so the window keeps moving.
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) offer(OP_SEND, 8'($urandom));
            else if (pick < 70) offer(OP_ACK, 8'($urandom_range(1, seq_span)));
            else if (pick < 85) offer(OP_IDLE, 8'($urandom));
            else if (pick < 93) offer(OP_ACK, 8'($urandom));
            else offer(OP_NOP, 8'($urandom));
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SEQ_COUNT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        opcode    <= OP_NOP;
        ack_byte  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults, then a total of zero while nothing is acked yet.
        offer(OP_NOP, 8'h00);
        offer(OP_SEND, 8'hFF);
        offer(OP_IDLE, 8'h00);
        drain_results();
        write_reg(CFG_TOTAL_PACKETS, 16'd0);
        cfg_we <= 1'b0;
        offer(OP_SEND, 8'h00);
        offer(OP_NOP, 8'h00);
        drain_results();
        write_reg(CFG_TOTAL_PACKETS, 16'd32);
        cfg_we <= 1'b0;

        // The receiver holds off while the requests below keep coming.
        hold_off_due = 1'b1;

        // Fill the window to its size, then acks out of range and out of order.
        repeat (5) offer(OP_SEND, 8'h00);
        offer(OP_ACK, 8'd0);
        offer(OP_ACK, 8'd255);
        offer(OP_ACK, 8'd21);
        offer(OP_ACK, 8'd10);
        offer(OP_ACK, 8'd3);
        offer(OP_ACK, 8'd1);
        offer(OP_ACK, 8'd2);
        offer(OP_ACK, 8'd3);
        offer(OP_SEND, 8'h00);
        offer(OP_SEND, 8'h00);
        offer(OP_IDLE, 8'h00);
        offer(OP_IDLE, 8'h00);
        offer(OP_ACK, 8'd5);
        offer(OP_ACK, 8'd4);
        offer(OP_NOP, 8'hA5);

        // Upper data bits beyond the register width are dropped by the write.
        run_phase(16'hFF84, 16'd2, 16'd6, 16'd3, 100);
        run_phase(16'd64, 16'd32, 16'd65535, 16'd255, 100);
        run_phase(16'd0, 16'd0, 16'd1, 16'd0, 90);
        run_phase(16'd127, 16'd63, 16'd0, 16'd1, 90);
        run_phase(16'd9, 16'd7, 16'd20, 16'd5, 110);
        gaps_on = 1'b0;
        run_phase(16'd16, 16'd8, 16'd40, 16'd8, 110);

        drain_results();
        repeat (100) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sr_swm_pkg.sv
src/sr_swm_ctrl.sv
src/sr_swm_dp.sv
src/sr_send_window_manager.sv
verif/sr_swm_checker.sv
verif/tb_sr_send_window_manager.sv
